@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL. Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`else

`define ASSERT_CLK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

@@ src/pss_pkg.sv @@
package pss_pkg;

    // Window depth default; the top level can narrow it.
    localparam int MAX_PATTERN_BYTES_DEF = 8;

    // Packet and counter limits, fixed by the result field widths.
    localparam int MAX_PACKET_BYTES   = 128;
    localparam int PACKET_COUNT_LIMIT = 8192;

    localparam int POS_W = $clog2(MAX_PACKET_BYTES);      // match position
    localparam int OFF_W = $clog2(MAX_PACKET_BYTES + 1);  // offset, holds the limit
    localparam int CNT_W = $clog2(PACKET_COUNT_LIMIT);    // packet counters

    localparam int PAT_W     = 64;  // pattern register
    localparam int LEN_W     = 4;   // pattern length register
    localparam int CFG_IDX_W = 2;
    localparam int IN_DATA_W = 8;

    localparam int OUT_FIELDS_W = 1 + POS_W + CNT_W + CNT_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_BYTES  = 2'd0,
        CFG_PATTERN_LENGTH = 2'd1
    } cfg_reg_t;

endpackage

@@ src/packet_string_search.sv @@
// Result path: a byte accepted into the window shows its result (on the last byte of a packet)
//   at m_tvalid from the output register: one register stage for the window, one for the result.
// Throughput: one byte per cycle, set by the single window compare stage; the output
//   register stalls the input only when a last byte meets a result not yet taken.
// Reset: aresetn, synchronous, active low; clears counters, per-packet state,
//   pattern (zero) and length (one). No clearing pass is needed.
`include "assert_macros.svh"

module packet_string_search
    import pss_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = MAX_PATTERN_BYTES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // Configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [PAT_W-1:0]      cfg_data,

    // Packet bytes
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                  s_tlast,   // last_of_packet

    // Per-packet results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // [0] found, [7:1] match_position,
                                             // [20:8] packet_index,
                                             // [33:21] packets_matched, rest zero
);

    // Configuration registers
    logic [PAT_W-1:0] pattern_reg;
    logic [LEN_W-1:0] pattern_len_reg;

    // Stage 1: byte window
    logic [7:0] win_reg [MAX_PATTERN_BYTES];
    logic       v1_reg;
    logic       last1_reg;

    // Stage 2: per-packet state and counters
    logic [OFF_W-1:0] offset_reg, offset_next;
    logic             seen_reg, seen_next;
    logic [POS_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0] pkt_cnt_reg, pkt_cnt_next;
    logic [CNT_W-1:0] match_cnt_reg, match_cnt_next;

    // Output register
    logic                    m_tvalid_reg;
    logic [OUT_FIELDS_W-1:0] m_fields_reg;

    logic             s_accept;
    logic             out_free;
    logic             adv2;
    logic [LEN_W-1:0] n_len;
    logic             hit;
    logic             in_range;
    logic             room;
    logic [OFF_W:0]   idx_plus1;
    logic [POS_W-1:0] start_pos;
    logic             take;

    // Handshakes
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign adv2      = v1_reg && (!last1_reg || out_free);
    assign s_tready  = !v1_reg || adv2;
    assign s_accept  = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, m_fields_reg};

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_reg     <= '0;
            pattern_len_reg <= LEN_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_PATTERN_BYTES:  pattern_reg     <= cfg_data;
                CFG_PATTERN_LENGTH: pattern_len_reg <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp pattern length into 1..MAX_PATTERN_BYTES
    always_comb begin
        if (pattern_len_reg == '0) begin
            n_len = LEN_W'(1);
        end else if (pattern_len_reg > LEN_W'(MAX_PATTERN_BYTES)) begin
            n_len = LEN_W'(MAX_PATTERN_BYTES);
        end else begin
            n_len = pattern_len_reg;
        end
    end

    // Shift the accepted byte into the window
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            win_reg[0] <= s_tdata;
            for (int k = 1; k < MAX_PATTERN_BYTES; k++) begin
                win_reg[k] <= win_reg[k-1];
            end
            last1_reg <= s_tlast;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (s_accept) begin
            v1_reg <= 1'b1;
        end else if (adv2) begin
            v1_reg <= 1'b0;
        end
    end

    // Compare the newest n window bytes with the pattern, one compare per length
    always_comb begin
        logic len_ok;
        hit = 1'b0;
        for (int k = 1; k <= MAX_PATTERN_BYTES; k++) begin
            len_ok = 1'b1;
            for (int i = 0; i < k; i++) begin
                if (win_reg[k-1-i] != pattern_reg[8*i +: 8]) begin
                    len_ok = 1'b0;
                end
            end
            if (n_len == LEN_W'(k) && len_ok) begin
                hit = 1'b1;
            end
        end
    end

    // Record the first match that lies wholly inside the packet
    assign in_range  = offset_reg < OFF_W'(MAX_PACKET_BYTES);
    assign idx_plus1 = {1'b0, offset_reg} + (OFF_W+1)'(1);
    assign room      = idx_plus1 >= (OFF_W+1)'(n_len);
    assign start_pos = POS_W'(idx_plus1 - (OFF_W+1)'(n_len));
    assign take      = in_range && room && !seen_reg && hit;

    always_comb begin
        seen_next      = seen_reg || take;
        first_next     = take ? start_pos : first_reg;
        offset_next    = in_range ? offset_reg + OFF_W'(1) : offset_reg;
        match_cnt_next = match_cnt_reg;
        pkt_cnt_next   = pkt_cnt_reg;
        if (last1_reg) begin
            if (seen_next && match_cnt_reg != CNT_W'(PACKET_COUNT_LIMIT - 1)) begin
                match_cnt_next = match_cnt_reg + CNT_W'(1);
            end
            if (pkt_cnt_reg == CNT_W'(PACKET_COUNT_LIMIT - 1)) begin
                pkt_cnt_next = '0;
            end else begin
                pkt_cnt_next = pkt_cnt_reg + CNT_W'(1);
            end
        end
    end

    // Advance per-packet state; clear it after the last byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg    <= '0;
            seen_reg      <= 1'b0;
            first_reg     <= '0;
            pkt_cnt_reg   <= '0;
            match_cnt_reg <= '0;
        end else if (adv2) begin
            pkt_cnt_reg   <= pkt_cnt_next;
            match_cnt_reg <= match_cnt_next;
            if (last1_reg) begin
                offset_reg <= '0;
                seen_reg   <= 1'b0;
                first_reg  <= '0;
            end else begin
                offset_reg <= offset_next;
                seen_reg   <= seen_next;
                first_reg  <= first_next;
            end
        end
    end

    // Load the result word on the last byte; hold it until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv2 && last1_reg) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv2 && last1_reg) begin
            m_fields_reg <= {match_cnt_next, pkt_cnt_reg,
                             seen_next ? first_next : POS_W'(0), seen_next};
        end
    end

    `ASSERT_CLK(a_no_pos_without_found, (m_tvalid_reg && !m_fields_reg[0]) |-> (m_fields_reg[POS_W:1] == '0), "match position set without a match")
    `ASSERT_CLK(a_packet_state_cleared, (adv2 && last1_reg) |=> (offset_reg == '0 && !seen_reg), "per-packet state not cleared after last byte")
    `ASSERT_CLK(a_result_loaded, (adv2 && last1_reg) |=> m_tvalid_reg, "last byte produced no result word")
    `ASSERT_CLK(a_no_result_overwrite, (m_tvalid_reg && !m_tready) |-> !(adv2 && last1_reg), "result word overwritten while stalled")
    `ASSERT_CLK(a_offset_bound, offset_reg <= OFF_W'(MAX_PACKET_BYTES), "byte offset beyond packet limit")

endmodule
